/* design/score_command_stream_parser_assert.svh */
// Assertion macros for the score command stream parser.
`ifndef SCORE_COMMAND_STREAM_PARSER_ASSERT_SVH
`define SCORE_COMMAND_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCSP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scsp same-cycle check failed");

// Next-cycle implication.
`define SCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scsp next-cycle check failed");

`endif

/* design/scsp_pkg.sv */
`timescale 1ns / 1ps
package scsp_pkg;

  localparam int QueueDepth = 4;

  localparam logic [15:0] TempoRecipReset = 16'd256;
  localparam logic [7:0]  ReleaseGapReset = 8'd20;

  localparam int AddrWidth = 3;
  localparam logic [AddrWidth-1:0] ADDR_TEMPO_RECIP = 3'd0;
  localparam logic [AddrWidth-1:0] ADDR_RELEASE_GAP = 3'd4;

  localparam logic [3:0] OP_NOTE_OFF = 4'h8;
  localparam logic [3:0] OP_NOTE_ON  = 4'h9;
  localparam logic [3:0] OP_RESTART  = 4'hE;
  localparam logic [3:0] OP_STOP     = 4'hF;

  typedef enum logic [2:0] {
    EV_NOTE_ON  = 3'd0,
    EV_NOTE_OFF = 3'd1,
    EV_DELAY    = 3'd2,
    EV_STOP     = 3'd3,
    EV_RESTART  = 3'd4,
    EV_BAD      = 3'd5
  } event_kind_t;

  // One queued command: optional release gap, then optional main event.
  typedef struct packed {
    logic        gap;
    logic        main;
    event_kind_t kind;
    logic [3:0]  chan;
    logic [7:0]  note;
    logic [14:0] dval;
  } cmd_t;

endpackage

/* design/scsp_front.sv */
`timescale 1ns / 1ps
module scsp_front
  import scsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       score_valid,
  input  logic [7:0] score_byte,
  output logic       score_stall,
  input  logic       q_full,
  output logic       push_valid,
  output cmd_t       push_data
);

  typedef enum logic [2:0] {
    PH_CMD  = 3'b001,
    PH_NOTE = 3'b010,
    PH_DLY  = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [6:0] held_byte, held_byte_next;
  logic       after_note_off, after_note_off_next;
  logic       stopped, stopped_next;
  logic       accept;
  logic [3:0] op;

  assign score_stall = q_full;
  assign accept      = score_valid && !q_full;
  assign op          = score_byte[7:4];

  always_comb begin
    phase_next          = phase;
    held_byte_next      = held_byte;
    after_note_off_next = after_note_off;
    stopped_next        = stopped;
    push_valid          = 1'b0;
    push_data           = '0;
    if (accept && !stopped) begin
      unique case (phase)
        PH_NOTE: begin
          push_valid     = 1'b1;
          push_data.main = 1'b1;
          push_data.kind = EV_NOTE_ON;
          push_data.chan = held_byte[3:0];
          push_data.note = score_byte;
          phase_next     = PH_CMD;
        end
        PH_DLY: begin
          push_valid     = 1'b1;
          push_data.main = 1'b1;
          push_data.kind = EV_DELAY;
          push_data.dval = {held_byte, score_byte};
          phase_next     = PH_CMD;
        end
        default: begin
          phase_next = PH_CMD;
          if (op == OP_NOTE_OFF) begin
            push_valid          = 1'b1;
            push_data.main      = 1'b1;
            push_data.kind      = EV_NOTE_OFF;
            push_data.chan      = score_byte[3:0];
            after_note_off_next = 1'b1;
          end else begin
            push_data.gap       = after_note_off;
            after_note_off_next = 1'b0;
            priority if (op == OP_NOTE_ON) begin
              held_byte_next = score_byte[6:0];
              phase_next     = PH_NOTE;
            end else if (!score_byte[7]) begin
              held_byte_next = score_byte[6:0];
              phase_next     = PH_DLY;
            end else if (op == OP_STOP) begin
              push_data.main = 1'b1;
              push_data.kind = EV_STOP;
              stopped_next   = 1'b1;
            end else if (op == OP_RESTART) begin
              push_data.main = 1'b1;
              push_data.kind = EV_RESTART;
            end else begin
              push_data.main = 1'b1;
              push_data.kind = EV_BAD;
            end
            push_valid = push_data.gap || push_data.main;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      held_byte      <= '0;
      after_note_off <= 1'b0;
      stopped        <= 1'b0;
    end else begin
      phase          <= phase_next;
      held_byte      <= held_byte_next;
      after_note_off <= after_note_off_next;
      stopped        <= stopped_next;
    end
  end

endmodule

/* design/scsp_cmd_queue.sv */
`timescale 1ns / 1ps
module scsp_cmd_queue
  import scsp_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic full,
  output logic head_valid,
  output cmd_t head_data,
  input  logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count, count_next;
  logic            do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

/* design/scsp_back.sv */
`timescale 1ns / 1ps
module scsp_back
  import scsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head_data,
  output logic        pop,
  input  logic [15:0] tempo_recip,
  input  logic [7:0]  release_gap,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  event_kind,
  output logic [3:0]  channel,
  output logic [7:0]  note_number,
  output logic [23:0] delay_ticks,
  output logic        last_of_run
);

  // execute stage
  logic        e_valid;
  cmd_t        e_rec;
  logic [30:0] e_prod;
  logic        e_second;

  logic        o_load, e_fire, e_done, gap_turn;
  event_kind_t ev_kind;
  logic [3:0]  ev_chan;
  logic [7:0]  ev_note;
  logic [23:0] ev_ticks;
  logic        ev_last;

  assign o_load   = !event_valid || !event_stall;
  assign e_fire   = e_valid && o_load;
  assign gap_turn = e_rec.gap && !e_second;
  assign e_done   = e_fire && !(gap_turn && e_rec.main);
  assign pop      = head_valid && (!e_valid || e_done);

  always_comb begin
    if (gap_turn) begin
      ev_kind  = EV_DELAY;
      ev_chan  = '0;
      ev_note  = '0;
      ev_ticks = {16'd0, release_gap};
      ev_last  = !e_rec.main;
    end else begin
      ev_kind  = e_rec.kind;
      ev_chan  = e_rec.chan;
      ev_note  = e_rec.note;
      // product is at most 31 bits, so the scaled value never saturates
      ev_ticks = (e_rec.kind == EV_DELAY) ? {1'b0, e_prod[30:8]} : '0;
      ev_last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e_rec  <= head_data;
      e_prod <= {16'd0, head_data.dval} * {15'd0, tempo_recip};
    end
    if (e_fire) begin
      event_kind  <= ev_kind;
      channel     <= ev_chan;
      note_number <= ev_note;
      delay_ticks <= ev_ticks;
      last_of_run <= ev_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid     <= 1'b0;
      e_second    <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      if (pop) begin
        e_valid  <= 1'b1;
        e_second <= 1'b0;
      end else if (e_done) begin
        e_valid <= 1'b0;
      end else if (e_fire) begin
        e_second <= 1'b1;
      end
      if (o_load) begin
        event_valid <= e_valid;
      end
    end
  end

endmodule

/* design/score_command_stream_parser.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake                  Payload
// score     in   score_valid / score_stall  score_byte
// event     out  event_valid / event_stall  event_kind, channel, note_number,
//                                           delay_ticks, last_of_run
// config    in   APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One score byte is taken per cycle while the queue is not full; a byte that
// yields two events (release gap plus stop, restart or bad command) holds the
// execute stage until both are out. Byte to event runs through the command
// queue, the execute stage with the delay multiplier and the output register.
// Reset clears the parser, the command queue and the output; tempo_recip
// returns to 256 and release_gap to 20.
// event_stall backs up through the output register, the execute stage and
// the command queue; score_stall rises only when the queue is full.
module score_command_stream_parser
  import scsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 score_valid,
  output logic                 score_stall,
  input  logic [7:0]           score_byte,
  output logic                 event_valid,
  input  logic                 event_stall,
  output logic [2:0]           event_kind,
  output logic [3:0]           channel,
  output logic [7:0]           note_number,
  output logic [23:0]          delay_ticks,
  output logic                 last_of_run,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

`include "score_command_stream_parser_assert.svh"

  logic        tempo_recip_q;
  logic [15:0] tempo_recip;
  logic [7:0]  release_gap;
  logic        cfg_write;
  logic        q_full, push_valid, head_valid, pop;
  cmd_t        push_data, head_data;

  assign tempo_recip_q = 1'b0;
  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      ADDR_TEMPO_RECIP: prdata = {16'd0, tempo_recip};
      ADDR_RELEASE_GAP: prdata = {24'd0, release_gap};
      default:          prdata = {31'd0, tempo_recip_q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_recip <= TempoRecipReset;
      release_gap <= ReleaseGapReset;
    end else if (cfg_write) begin
      if (paddr == ADDR_TEMPO_RECIP) begin
        tempo_recip <= pwdata[15:0];
      end
      if (paddr == ADDR_RELEASE_GAP) begin
        release_gap <= pwdata[7:0];
      end
    end
  end

  scsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .score_valid (score_valid),
    .score_byte  (score_byte),
    .score_stall (score_stall),
    .q_full      (q_full),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  scsp_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  scsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .tempo_recip (tempo_recip),
    .release_gap (release_gap),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .channel     (channel),
    .note_number (note_number),
    .delay_ticks (delay_ticks),
    .last_of_run (last_of_run)
  );

  // only a release gap can precede another event of the same byte
  `SCSP_ASSERT_SAME(a_first_is_gap, event_valid && !last_of_run, event_kind == EV_DELAY)
  // the second event of a byte follows its gap directly
  `SCSP_ASSERT_NEXT(a_pair_back_to_back, event_valid && !event_stall && !last_of_run, event_valid)
  // nothing follows a delivered stop
  `SCSP_ASSERT_NEXT(a_quiet_after_stop, event_valid && !event_stall && event_kind == EV_STOP, !event_valid)

endmodule
